>>> rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion shorthands; each samples on clk, and CMBC_ASSERT expects rst_n in scope.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked only outside reset.
`define CMBC_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked at every edge, reset included.
`define CMBC_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> rtl/cmbc_pkg.sv
// ----------------------------------------------------------------------------
// cmbc_pkg
// Types and constants shared by the cover motor button controller.
// ----------------------------------------------------------------------------
`default_nettype none

package cmbc_pkg;

    localparam int unsigned THR_W     = 10;
    localparam int unsigned TICKS_W   = 16;
    localparam int unsigned POS_W     = 7;
    localparam int unsigned SPEED_W   = 10;
    localparam int unsigned VEL_W     = 11;
    localparam int unsigned CFG_IDX_W = 3;
    localparam int unsigned CFG_W     = 16;
    localparam int unsigned QUEUE_DEPTH = 2;

    localparam logic [POS_W-1:0]   MID_POSITION = 7'd50;
    localparam logic [SPEED_W-1:0] SPEED_MAX    = 10'd1000;

    typedef enum logic [1:0] {
        KIND_TICK   = 2'd0,
        KIND_CMD    = 2'd1,
        KIND_TOP    = 2'd2,
        KIND_BOTTOM = 2'd3
    } kind_t;

    typedef enum logic [1:0] {
        CMD_OPEN  = 2'd0,
        CMD_CLOSE = 2'd1,
        CMD_STOP  = 2'd2,
        CMD_NONE  = 2'd3
    } cmd_t;

    typedef enum logic [2:0] {
        PRESS_UP        = 3'd0,
        PRESS_DOWN      = 3'd1,
        PRESS_IDLE      = 3'd2,
        PRESS_UP_HELD   = 3'd3,
        PRESS_DOWN_HELD = 3'd4,
        PRESS_HELD_END  = 3'd5
    } btn_t;

    // Last-button code: up, down, none as in btn_t, plus this one.
    localparam logic [1:0] LAST_RELEASE = 2'd3;

    typedef enum logic [1:0] {
        MOT_UP      = 2'd0,
        MOT_DOWN    = 2'd1,
        MOT_STOPPED = 2'd2
    } motor_t;

    typedef enum logic [1:0] {
        EDGE_TOP    = 2'd0,
        EDGE_BOTTOM = 2'd1,
        EDGE_MIDDLE = 2'd2
    } edge_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_UP_THRESHOLD     = 3'd0,
        CFG_DOWN_THRESHOLD   = 3'd1,
        CFG_LONG_PRESS_TICKS = 3'd2,
        CFG_OPEN_POSITION    = 3'd3,
        CFG_CLOSED_POSITION  = 3'd4,
        CFG_DRIVE_SPEED      = 3'd5
    } cfg_idx_t;

    typedef struct packed {
        logic [THR_W-1:0]   up_threshold;
        logic [THR_W-1:0]   down_threshold;
        logic [TICKS_W-1:0] long_press_ticks;
        logic [POS_W-1:0]   open_position;
        logic [POS_W-1:0]   closed_position;
        logic [SPEED_W-1:0] drive_speed;
    } cfg_t;

    // Classified request handed from the front end to the drive back end.
    typedef struct packed {
        kind_t kind;
        btn_t  shown;
        cmd_t  cmd;
    } act_t;

endpackage

`default_nettype wire

>>> rtl/cmbc_queue.sv
// ----------------------------------------------------------------------------
// cmbc_queue
// Small register queue between the classifier and the drive back end.
// ----------------------------------------------------------------------------
`default_nettype none

module cmbc_queue #(
    parameter int unsigned DEPTH = 2
) (
    input  wire             clk,
    input  wire             rst_n,
    input  wire             push,
    input  cmbc_pkg::act_t  push_data,
    output logic            full,
    input  wire             pop,
    output logic            not_empty,
    output cmbc_pkg::act_t  pop_data
);

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);

    cmbc_pkg::act_t   mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    assign full      = (count_reg == CNT_W'(DEPTH));
    assign not_empty = (count_reg != '0);
    assign pop_data  = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

`default_nettype wire

>>> rtl/cmbc_front.sv
// ----------------------------------------------------------------------------
// cmbc_front
// Button ladder classifier and short/long press detector.
// ----------------------------------------------------------------------------
`default_nettype none

module cmbc_front #(
    parameter int unsigned HOLD_COUNT_BITS = 16
) (
    input  wire                           clk,
    input  wire                           rst_n,
    input  cmbc_pkg::cfg_t                cfg,
    input  wire                           take,
    input  cmbc_pkg::kind_t               kind,
    input  wire [cmbc_pkg::THR_W-1:0]     adc_sample,
    input  cmbc_pkg::cmd_t                command,
    output cmbc_pkg::act_t                act
);

    localparam int unsigned CMP_W =
        (HOLD_COUNT_BITS > cmbc_pkg::TICKS_W) ? HOLD_COUNT_BITS : cmbc_pkg::TICKS_W;

    logic [1:0]                 last_reg, last_next;
    logic [HOLD_COUNT_BITS-1:0] hold_reg, hold_next;
    logic                       long_reg, long_next;
    cmbc_pkg::btn_t             cls;
    cmbc_pkg::btn_t             shown;

    always_comb
    begin
        priority if (adc_sample > cfg.up_threshold)
        begin
            cls = cmbc_pkg::PRESS_UP;
        end
        else if (adc_sample > cfg.down_threshold)
        begin
            cls = cmbc_pkg::PRESS_DOWN;
        end
        else
        begin
            cls = cmbc_pkg::PRESS_IDLE;
        end
    end

    // Press detector; state moves only on tick requests.
    always_comb
    begin
        last_next = last_reg;
        hold_next = hold_reg;
        long_next = long_reg;
        shown     = cmbc_pkg::PRESS_IDLE;
        if (kind == cmbc_pkg::KIND_TICK)
        begin
            shown = cls;
            if ({1'b0, last_reg} != cls)
            begin
                last_next = cls[1:0];
                if (long_reg)
                begin
                    shown     = cmbc_pkg::PRESS_HELD_END;
                    last_next = cmbc_pkg::LAST_RELEASE;
                    long_next = 1'b0;
                end
                hold_next = '0;
            end
            else if (hold_reg != '1)
            begin
                hold_next = hold_reg + 1'b1;
            end
            if (CMP_W'(hold_next) > CMP_W'(cfg.long_press_ticks))
            begin
                if (shown == cmbc_pkg::PRESS_DOWN)
                begin
                    shown     = cmbc_pkg::PRESS_DOWN_HELD;
                    long_next = 1'b1;
                end
                else if (shown == cmbc_pkg::PRESS_UP)
                begin
                    shown     = cmbc_pkg::PRESS_UP_HELD;
                    long_next = 1'b1;
                end
            end
        end
    end

    assign act.kind  = kind;
    assign act.shown = shown;
    assign act.cmd   = command;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_reg <= 2'(cmbc_pkg::PRESS_IDLE);
            hold_reg <= '0;
            long_reg <= 1'b0;
        end
        else if (take)
        begin
            last_reg <= last_next;
            hold_reg <= hold_next;
            long_reg <= long_next;
        end
    end

endmodule

`default_nettype wire

>>> rtl/cmbc_back.sv
// ----------------------------------------------------------------------------
// cmbc_back
// Drive state, edge latch, position reporting and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module cmbc_back (
    input  wire                  clk,
    input  wire                  rst_n,
    input  cmbc_pkg::cfg_t       cfg,
    input  wire                  act_valid,
    input  cmbc_pkg::act_t       act,
    output logic                 act_pop,
    output logic                 res_valid,
    input  wire                  res_ready,
    output logic [23:0]          res_data
);

    cmbc_pkg::motor_t             mot_reg, mot_next;
    cmbc_pkg::edge_t              edge_reg, edge_next;
    logic [cmbc_pkg::POS_W-1:0]   pos_reg, pos_next;
    logic                         valid_reg;
    logic [23:0]                  data_reg, data_next;
    logic                         rep;
    logic [cmbc_pkg::SPEED_W-1:0] speed;
    logic [cmbc_pkg::VEL_W-1:0]   vel;
    logic                         go_up, go_down, halt;

    assign act_pop   = act_valid && (!valid_reg || res_ready);
    assign res_valid = valid_reg;
    assign res_data  = data_reg;

    always_comb
    begin
        go_up   = 1'b0;
        go_down = 1'b0;
        halt    = 1'b0;
        unique case (act.kind)
            cmbc_pkg::KIND_TICK:
            begin
                go_up   = (act.shown == cmbc_pkg::PRESS_UP) &&
                          (edge_reg != cmbc_pkg::EDGE_TOP);
                go_down = (act.shown == cmbc_pkg::PRESS_DOWN) &&
                          (edge_reg != cmbc_pkg::EDGE_BOTTOM);
                halt    = (act.shown == cmbc_pkg::PRESS_HELD_END);
            end
            cmbc_pkg::KIND_CMD:
            begin
                go_up   = (act.cmd == cmbc_pkg::CMD_OPEN);
                go_down = (act.cmd == cmbc_pkg::CMD_CLOSE);
                halt    = (act.cmd == cmbc_pkg::CMD_STOP);
            end
            default:
            begin
            end
        endcase
    end

    always_comb
    begin
        mot_next  = mot_reg;
        edge_next = edge_reg;
        pos_next  = pos_reg;
        rep       = 1'b0;
        if (act.kind == cmbc_pkg::KIND_TOP)
        begin
            if (mot_reg == cmbc_pkg::MOT_UP)
            begin
                mot_next = cmbc_pkg::MOT_STOPPED;
            end
            edge_next = cmbc_pkg::EDGE_TOP;
            pos_next  = cfg.open_position;
            rep       = 1'b1;
        end
        else if (act.kind == cmbc_pkg::KIND_BOTTOM)
        begin
            if (mot_reg == cmbc_pkg::MOT_DOWN)
            begin
                mot_next = cmbc_pkg::MOT_STOPPED;
            end
            edge_next = cmbc_pkg::EDGE_BOTTOM;
            pos_next  = cfg.closed_position;
            rep       = 1'b1;
        end
        else
        begin
            if (go_up)
            begin
                if (edge_reg == cmbc_pkg::EDGE_BOTTOM)
                begin
                    edge_next = cmbc_pkg::EDGE_MIDDLE;
                end
                mot_next = cmbc_pkg::MOT_UP;
            end
            else if (go_down)
            begin
                if (edge_reg == cmbc_pkg::EDGE_TOP)
                begin
                    edge_next = cmbc_pkg::EDGE_MIDDLE;
                end
                mot_next = cmbc_pkg::MOT_DOWN;
            end
            else if (halt)
            begin
                mot_next = cmbc_pkg::MOT_STOPPED;
            end
            // Any running drive publishes mid once.
            if (mot_next != cmbc_pkg::MOT_STOPPED && pos_reg != cmbc_pkg::MID_POSITION)
            begin
                pos_next = cmbc_pkg::MID_POSITION;
                rep      = 1'b1;
            end
        end
    end

    always_comb
    begin
        speed = (cfg.drive_speed > cmbc_pkg::SPEED_MAX) ? cmbc_pkg::SPEED_MAX
                                                        : cfg.drive_speed;
        unique case (mot_next)
            cmbc_pkg::MOT_UP:   vel = -{1'b0, speed};
            cmbc_pkg::MOT_DOWN: vel = {1'b0, speed};
            default:            vel = '0;
        endcase
        data_next = {edge_next, act.shown, pos_next, rep, vel};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mot_reg   <= cmbc_pkg::MOT_STOPPED;
            edge_reg  <= cmbc_pkg::EDGE_TOP;
            pos_reg   <= cmbc_pkg::MID_POSITION;
            valid_reg <= 1'b0;
        end
        else
        begin
            if (act_pop)
            begin
                mot_reg   <= mot_next;
                edge_reg  <= edge_next;
                pos_reg   <= pos_next;
                valid_reg <= 1'b1;
            end
            else if (res_ready)
            begin
                valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (act_pop)
        begin
            data_reg <= data_next;
        end
    end

endmodule

`default_nettype wire

>>> rtl/cover_motor_button_controller.sv
// ----------------------------------------------------------------------------
// cover_motor_button_controller
// Window-cover drive controller: button ladder, remote commands, reed edges.
// ----------------------------------------------------------------------------
//
//  channel | dir | handshake          | payload
//  --------+-----+--------------------+------------------------------------
//  s_*     | in  | s_tvalid/s_tready  | tuser: mode; tdata: sample, command
//  m_*     | out | m_tvalid/m_tready  | tdata: velocity, report, pos, class, edge
//  cfg_*   | in  | cfg_we             | cfg_index selects, cfg_data value
//
//  One request in, one result out; a new request is taken every cycle while the queue has room.
//  A taken request is written into the queue; the back end then loads its result
//  into the result register, from which the result is offered.
//  The back end pops the queue whenever its result register is empty or drained,
//  so a stalled m_tready only fills the two-entry queue before s_tready drops.
//  Reset (rst_n low, async) loads the register defaults, stops the drive,
//  latches the top edge and sets the position to mid.
//
`default_nettype none

module cover_motor_button_controller #(
    parameter int unsigned HOLD_COUNT_BITS = 16
) (
    input  wire                               clk,
    input  wire                               rst_n,
    // request channel
    input  wire                               s_tvalid,
    output logic                              s_tready,
    input  wire  [15:0]                       s_tdata,  // [9:0] adc_sample, [11:10] command
    input  wire  [1:0]                        s_tuser,  // [1:0] mode
    // result channel
    output logic                              m_tvalid,
    input  wire                               m_tready,
    output logic [23:0]                       m_tdata,  // [10:0] motor_velocity,
                                                        // [11] position_report_valid,
                                                        // [18:12] position_value,
                                                        // [21:19] button_class,
                                                        // [23:22] edge_state
    // configuration write port
    input  wire                               cfg_we,
    input  wire  [cmbc_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire  [cmbc_pkg::CFG_W-1:0]        cfg_data
);

    cmbc_pkg::cfg_t cfg_reg;
    cmbc_pkg::act_t front_act;
    cmbc_pkg::act_t queue_act;
    logic           take;
    logic           queue_full;
    logic           queue_valid;
    logic           queue_pop;

    // Configuration registers; writes past the list are dropped.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.up_threshold     <= 10'd700;
            cfg_reg.down_threshold   <= 10'd300;
            cfg_reg.long_press_ticks <= 16'd500;
            cfg_reg.open_position    <= 7'd100;
            cfg_reg.closed_position  <= 7'd0;
            cfg_reg.drive_speed      <= 10'd500;
        end
        else if (cfg_we)
        begin
            unique case (cmbc_pkg::cfg_idx_t'(cfg_index))
                cmbc_pkg::CFG_UP_THRESHOLD:
                    cfg_reg.up_threshold <= cfg_data[cmbc_pkg::THR_W-1:0];
                cmbc_pkg::CFG_DOWN_THRESHOLD:
                    cfg_reg.down_threshold <= cfg_data[cmbc_pkg::THR_W-1:0];
                cmbc_pkg::CFG_LONG_PRESS_TICKS:
                    cfg_reg.long_press_ticks <= cfg_data[cmbc_pkg::TICKS_W-1:0];
                cmbc_pkg::CFG_OPEN_POSITION:
                    cfg_reg.open_position <= cfg_data[cmbc_pkg::POS_W-1:0];
                cmbc_pkg::CFG_CLOSED_POSITION:
                    cfg_reg.closed_position <= cfg_data[cmbc_pkg::POS_W-1:0];
                cmbc_pkg::CFG_DRIVE_SPEED:
                    cfg_reg.drive_speed <= cfg_data[cmbc_pkg::SPEED_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    // A request is taken whenever the queue has room.
    assign s_tready = !queue_full;
    assign take     = s_tvalid && !queue_full;

    cmbc_front #(
        .HOLD_COUNT_BITS (HOLD_COUNT_BITS)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .take       (take),
        .kind       (cmbc_pkg::kind_t'(s_tuser)),
        .adc_sample (s_tdata[9:0]),
        .command    (cmbc_pkg::cmd_t'(s_tdata[11:10])),
        .act        (front_act)
    );

    cmbc_queue #(
        .DEPTH (cmbc_pkg::QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (take),
        .push_data (front_act),
        .full      (queue_full),
        .pop       (queue_pop),
        .not_empty (queue_valid),
        .pop_data  (queue_act)
    );

    cmbc_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .act_valid (queue_valid),
        .act       (queue_act),
        .act_pop   (queue_pop),
        .res_valid (m_tvalid),
        .res_ready (m_tready),
        .res_data  (m_tdata)
    );

endmodule

`default_nettype wire

>>> rtl/cmbc_checker.sv
// ----------------------------------------------------------------------------
// cmbc_checker
// Port-level checks for the cover motor button controller.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module cmbc_checker (
    input wire        clk,
    input wire        rst_n,
    input wire        m_tvalid,
    input wire        m_tready,
    input wire [23:0] m_tdata
);

    `CMBC_ASSERT(a_hold_valid, m_tvalid && !m_tready |=> m_tvalid, "result dropped while stalled")
    `CMBC_ASSERT(a_hold_data, m_tvalid && !m_tready |=> $stable(m_tdata), "stalled result changed")
    `CMBC_ASSERT(a_vel_range, m_tvalid |-> ($signed(m_tdata[10:0]) <= 11'sd1000) && ($signed(m_tdata[10:0]) >= -11'sd1000), "velocity out of range")
    `CMBC_ASSERT(a_codes, m_tvalid |-> (m_tdata[21:19] <= 3'd5) && (m_tdata[23:22] != 2'd3), "bad class or edge code")
    `CMBC_ASSERT_ALWAYS(a_reset_quiet, !rst_n |-> !m_tvalid, "result valid in reset")

endmodule

bind cover_motor_button_controller cmbc_checker u_cmbc_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

`default_nettype wire

>>> test/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Checks the cover motor button controller against a behavioral predictor:
// a directed table (reset values, edges, every command, press thresholds,
// long press and release), then random phases of button runs, commands and
// reed events under several register settings, with random gaps on the
// request side and stalls on the result side.
// ----------------------------------------------------------------------------
module testbench;
    import cmbc_pkg::*;

    localparam int HOLD_BITS   = 16;
    localparam int MAX_GAP     = 12;     // longest idle draw on either side
    localparam int SETTLE      = 4;      // idle cycles before a register write
    localparam int QUIET_LIMIT = 1000;   // cycles with no handshake before giving up
    localparam int PHASES      = 6;
    localparam int PHASE_ITEMS = 305;

    // Result fields, highest bits first so the struct overlays m_tdata.
    typedef struct packed {
        edge_t              edge_state;
        btn_t               button;
        logic [POS_W-1:0]   position;
        logic               report;
        logic [VEL_W-1:0]   velocity;
    } result_t;

    // One row of the directed table: a register write or a request.
    typedef struct {
        bit                 is_write;
        cfg_idx_t           reg_idx;
        logic [CFG_W-1:0]   reg_value;
        kind_t              mode;
        logic [THR_W-1:0]   sample;
        cmd_t               cmd;
        bit                 typed;     // want holds a hand-written result
        result_t            want;
    } plan_row_t;

    logic               clk;
    logic               rst_n;
    logic               s_tvalid;
    logic               s_tready;
    logic [15:0]        s_tdata;     // [9:0] adc_sample, [11:10] command
    logic [1:0]         s_tuser;     // [1:0] mode
    logic               m_tvalid;
    logic               m_tready;
    logic [23:0]        m_tdata;     // [10:0] velocity, [11] report, [18:12] position,
                                     // [21:19] button class, [23:22] edge state
    logic               cfg_we;
    cfg_idx_t           cfg_index;
    logic [CFG_W-1:0]   cfg_data;

    // Predictor copy of registers and state.
    cfg_t               settings;
    logic [1:0]         last_btn;
    logic [HOLD_BITS-1:0] hold_count;
    bit                 long_held;
    motor_t             motor;
    edge_t              at_edge;
    logic [POS_W-1:0]   position;
    bit                 published;

    result_t            pending_results[$];   // expected results, oldest first
    plan_row_t          plan[$];
    int                 mismatches;
    int                 quiet_cycles;
    bit                 sender_calm;
    bit                 taker_calm;
    btn_t               held;                 // class of the current button run
    int                 run_left;

    cover_motor_button_controller #(.HOLD_COUNT_BITS(HOLD_BITS)) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        clk = 1'b0;
        #4;
        clk = 1'b1;
        #4;
    end

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------
    function automatic void reset_model();
        settings.up_threshold     = 10'd700;
        settings.down_threshold   = 10'd300;
        settings.long_press_ticks = 16'd500;
        settings.open_position    = 7'd100;
        settings.closed_position  = 7'd0;
        settings.drive_speed      = 10'd500;
        last_btn   = 2'(PRESS_IDLE);
        hold_count = '0;
        long_held  = 1'b0;
        motor      = MOT_STOPPED;
        at_edge    = EDGE_TOP;
        position   = MID_POSITION;
    endfunction

    // A running drive moves the reported position to mid, once.
    function automatic void publish_mid();
        if (position != MID_POSITION)
        begin
            position  = MID_POSITION;
            published = 1'b1;
        end
    endfunction

    function automatic void head_up();
        if (motor != MOT_UP)
            publish_mid();
        if (at_edge == EDGE_BOTTOM)
            at_edge = EDGE_MIDDLE;
        motor = MOT_UP;
    endfunction

    function automatic void head_down();
        if (motor != MOT_DOWN)
            publish_mid();
        if (at_edge == EDGE_TOP)
            at_edge = EDGE_MIDDLE;
        motor = MOT_DOWN;
    endfunction

    function automatic result_t cover_step(kind_t mode, logic [THR_W-1:0] sample, cmd_t cmd);
        btn_t               cls;
        btn_t               shown;
        logic [SPEED_W-1:0] speed;
        result_t            r;
        shown     = PRESS_IDLE;
        published = 1'b0;
        case (mode)
            KIND_TICK:
            begin
                if (sample > settings.up_threshold)
                    cls = PRESS_UP;
                else if (sample > settings.down_threshold)
                    cls = PRESS_DOWN;
                else
                    cls = PRESS_IDLE;
                shown = cls;
                // class change clears the count; ending a long press reports a release
                if (last_btn != 2'(cls))
                begin
                    last_btn = 2'(cls);
                    if (long_held)
                    begin
                        shown     = PRESS_HELD_END;
                        last_btn  = LAST_RELEASE;
                        long_held = 1'b0;
                    end
                    hold_count = '0;
                end
                else if (hold_count != '1)
                    hold_count++;
                if (hold_count > settings.long_press_ticks)
                begin
                    if (shown == PRESS_DOWN)
                    begin
                        shown     = PRESS_DOWN_HELD;
                        long_held = 1'b1;
                    end
                    else if (shown == PRESS_UP)
                    begin
                        shown     = PRESS_UP_HELD;
                        long_held = 1'b1;
                    end
                end
                case (shown)
                    PRESS_UP:       if (at_edge != EDGE_TOP) head_up();
                    PRESS_DOWN:     if (at_edge != EDGE_BOTTOM) head_down();
                    PRESS_HELD_END: motor = MOT_STOPPED;
                    default:        ;
                endcase
                if (motor != MOT_STOPPED)
                    publish_mid();
            end
            KIND_CMD:
            begin
                case (cmd)
                    CMD_OPEN:  head_up();      // no top-edge check
                    CMD_CLOSE: head_down();
                    CMD_STOP:  motor = MOT_STOPPED;
                    default:   ;
                endcase
                if (motor != MOT_STOPPED)
                    publish_mid();
            end
            KIND_TOP:
            begin
                if (motor == MOT_UP)
                    motor = MOT_STOPPED;
                at_edge   = EDGE_TOP;
                position  = settings.open_position;
                published = 1'b1;
            end
            default:
            begin
                if (motor == MOT_DOWN)
                    motor = MOT_STOPPED;
                at_edge   = EDGE_BOTTOM;
                position  = settings.closed_position;
                published = 1'b1;
            end
        endcase
        speed = (settings.drive_speed > SPEED_MAX) ? SPEED_MAX : settings.drive_speed;
        if (motor == MOT_UP)
            r.velocity = -{1'b0, speed};
        else if (motor == MOT_DOWN)
            r.velocity = {1'b0, speed};
        else
            r.velocity = '0;
        r.report     = published;
        r.position   = position;
        r.button     = shown;
        r.edge_state = at_edge;
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Directed table
    // ------------------------------------------------------------------
    function automatic result_t outcome(int vel, bit rep, int pos, btn_t cls, edge_t edg);
        result_t r;
        r.velocity   = VEL_W'(vel);
        r.report     = rep;
        r.position   = POS_W'(pos);
        r.button     = cls;
        r.edge_state = edg;
        return r;
    endfunction

    function automatic void add_row(kind_t mode, int sample, cmd_t cmd,
                                    bit typed = 1'b0, result_t want = '0);
        plan_row_t row;
        row.is_write  = 1'b0;
        row.reg_idx   = CFG_UP_THRESHOLD;
        row.reg_value = '0;
        row.mode      = mode;
        row.sample    = THR_W'(sample);
        row.cmd       = cmd;
        row.typed     = typed;
        row.want      = want;
        plan.push_back(row);
    endfunction

    function automatic void add_write(cfg_idx_t idx, int value);
        plan_row_t row;
        row.is_write  = 1'b1;
        row.reg_idx   = idx;
        row.reg_value = CFG_W'(value);
        row.mode      = KIND_TICK;
        row.sample    = '0;
        row.cmd       = CMD_NONE;
        row.typed     = 1'b0;
        row.want      = '0;
        plan.push_back(row);
    endfunction

    function automatic void build_plan();
        // reset registers: up above 700, down above 300
        add_row(KIND_TICK, 0, CMD_NONE, 1, outcome(0, 0, 50, PRESS_IDLE, EDGE_TOP));
        add_row(KIND_TICK, 1023, CMD_NONE, 1, outcome(0, 0, 50, PRESS_UP, EDGE_TOP)); // at top
        add_row(KIND_TICK, 500, CMD_NONE, 1, outcome(500, 0, 50, PRESS_DOWN, EDGE_MIDDLE));
        add_row(KIND_BOTTOM, 0, CMD_NONE, 1, outcome(0, 1, 0, PRESS_IDLE, EDGE_BOTTOM));
        add_row(KIND_CMD, 0, CMD_OPEN, 1, outcome(-500, 1, 50, PRESS_IDLE, EDGE_MIDDLE));
        add_row(KIND_TOP, 0, CMD_NONE, 1, outcome(0, 1, 100, PRESS_IDLE, EDGE_TOP));
        add_row(KIND_CMD, 0, CMD_OPEN);            // open ignores the top edge
        add_row(KIND_CMD, 0, CMD_STOP);
        add_row(KIND_CMD, 0, CMD_CLOSE);
        add_row(KIND_CMD, 0, CMD_NONE);            // unrecognized
        add_row(KIND_TOP, 0, CMD_NONE);            // reed while driving the other way
        add_row(KIND_TICK, 300, CMD_NONE);         // threshold boundaries
        add_row(KIND_TICK, 700, CMD_NONE);
        add_row(KIND_TICK, 701, CMD_NONE);
        // short long-press, clamped speed, positions of 100 and up
        add_write(CFG_LONG_PRESS_TICKS, 1);
        add_write(CFG_DRIVE_SPEED, 1023);
        add_write(CFG_OPEN_POSITION, 127);
        add_write(CFG_CLOSED_POSITION, 100);
        add_row(KIND_TICK, 1023, CMD_NONE);
        add_row(KIND_TICK, 1023, CMD_NONE);
        add_row(KIND_TICK, 1023, CMD_NONE);        // long up
        add_row(KIND_TICK, 0, CMD_NONE);           // long release
        add_row(KIND_TICK, 500, CMD_NONE);
        add_row(KIND_BOTTOM, 0, CMD_NONE);
        add_row(KIND_TOP, 0, CMD_NONE);
        // threshold extremes
        add_write(CFG_UP_THRESHOLD, 0);
        add_write(CFG_DOWN_THRESHOLD, 1023);
        add_row(KIND_TICK, 0, CMD_NONE);
        add_row(KIND_TICK, 1, CMD_NONE);
        add_write(CFG_UP_THRESHOLD, 1023);
        add_write(CFG_DOWN_THRESHOLD, 0);
        add_write(CFG_DRIVE_SPEED, 0);
        add_row(KIND_TICK, 1023, CMD_NONE);
        add_row(KIND_CMD, 0, CMD_OPEN);
    endfunction

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------
    // Per-item idle draw; calm stretches run with no idling at all.
    function automatic int draw_gap(inout bit calm);
        if ($urandom_range(39, 0) == 0)
            calm = !calm;
        return calm ? 0 : $urandom_range(MAX_GAP, 0);
    endfunction

    // Sample that lands in the given class under the current thresholds.
    function automatic logic [THR_W-1:0] sample_for(btn_t cls);
        int unsigned up_t;
        int unsigned dn_t;
        up_t = settings.up_threshold;
        dn_t = settings.down_threshold;
        case (cls)
            PRESS_UP:   if (up_t < 1023) return THR_W'($urandom_range(1023, up_t + 1));
            PRESS_DOWN: if (dn_t < up_t) return THR_W'($urandom_range(up_t, dn_t + 1));
            default:    return THR_W'($urandom_range((up_t < dn_t) ? up_t : dn_t, 0));
        endcase
        return THR_W'($urandom_range(1023, 0));    // class unreachable: anything
    endfunction

    // Called at a falling edge; returns at the falling edge after acceptance.
    task automatic send_request(kind_t mode, logic [THR_W-1:0] sample, cmd_t cmd,
                                bit typed, result_t want);
        int      gap;
        result_t guess;
        gap = draw_gap(sender_calm);
        repeat (gap)
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= mode;
        s_tdata  <= {4'b0, cmd, sample};
        do
            @(posedge clk);
        while (!s_tready);
        guess = cover_step(mode, sample, cmd);
        pending_results.push_back(typed ? want : guess);
        @(negedge clk);
    endtask

    // Only while idle: every result back, then the pipeline settles.
    task automatic write_register(cfg_idx_t idx, logic [CFG_W-1:0] value);
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0)
            @(negedge clk);
        repeat (SETTLE) @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(negedge clk);
        cfg_we    <= 1'b0;
        case (idx)
            CFG_UP_THRESHOLD:     settings.up_threshold     = value[THR_W-1:0];
            CFG_DOWN_THRESHOLD:   settings.down_threshold   = value[THR_W-1:0];
            CFG_LONG_PRESS_TICKS: settings.long_press_ticks = value[TICKS_W-1:0];
            CFG_OPEN_POSITION:    settings.open_position    = value[POS_W-1:0];
            CFG_CLOSED_POSITION:  settings.closed_position  = value[POS_W-1:0];
            CFG_DRIVE_SPEED:      settings.drive_speed      = value[SPEED_W-1:0];
            default:              ;
        endcase
    endtask

    task automatic apply_settings(int up_t, int dn_t, int ticks, int open_p, int closed_p,
                                  int speed);
        write_register(CFG_UP_THRESHOLD, CFG_W'(up_t));
        write_register(CFG_DOWN_THRESHOLD, CFG_W'(dn_t));
        write_register(CFG_LONG_PRESS_TICKS, CFG_W'(ticks));
        write_register(CFG_OPEN_POSITION, CFG_W'(open_p));
        write_register(CFG_CLOSED_POSITION, CFG_W'(closed_p));
        write_register(CFG_DRIVE_SPEED, CFG_W'(speed));
    endtask

    // Mostly held button runs, up to four ticks past the long-press count when it is below 16,
    // mixed with commands, reed events and some fully random noise.
    task automatic random_request();
        int unsigned roll;
        int unsigned span;
        roll = $urandom_range(99, 0);
        if (run_left == 0)
        begin
            held = btn_t'($urandom_range(2, 0));
            span = (settings.long_press_ticks < 16) ? settings.long_press_ticks + 4 : 12;
            run_left = $urandom_range(span, 1);
        end
        if (roll < 8)
            send_request(kind_t'($urandom_range(3, 0)), THR_W'($urandom_range(1023, 0)),
                         cmd_t'($urandom_range(3, 0)), 1'b0, '0);
        else if (roll < 70)
        begin
            run_left--;
            send_request(KIND_TICK, sample_for(held), cmd_t'($urandom_range(3, 0)), 1'b0, '0);
        end
        else if (roll < 86)
            send_request(KIND_CMD, THR_W'($urandom_range(1023, 0)),
                         cmd_t'($urandom_range(3, 0)), 1'b0, '0);
        else if (roll < 93)
            send_request(KIND_TOP, THR_W'($urandom_range(1023, 0)),
                         cmd_t'($urandom_range(3, 0)), 1'b0, '0);
        else
            send_request(KIND_BOTTOM, THR_W'($urandom_range(1023, 0)),
                         cmd_t'($urandom_range(3, 0)), 1'b0, '0);
    endtask

    // ------------------------------------------------------------------
    // Result side: random stalls, then field-by-field check
    // ------------------------------------------------------------------
    initial
    begin
        int stall;
        wait (rst_n === 1'b1);
        @(negedge clk);
        forever
        begin
            stall = draw_gap(taker_calm);
            repeat (stall)
            begin
                m_tready <= 1'b0;
                @(negedge clk);
            end
            m_tready <= 1'b1;
            do
                @(posedge clk);
            while (!m_tvalid);
            @(negedge clk);
        end
    end

    function automatic void check_field(string field, int want, int got);
        if (want != got)
        begin
            $display("%0t: %s expected %0d, got %0d", $time, field, want, got);
            mismatches++;
        end
    endfunction

    always @(posedge clk)
    begin
        result_t got;
        result_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            got = m_tdata;
            if (pending_results.size() == 0)
            begin
                $display("%0t: result %h with no request pending", $time, m_tdata);
                mismatches++;
            end
            else
            begin
                want = pending_results.pop_front();
                check_field("velocity", $signed(want.velocity), $signed(got.velocity));
                check_field("report", want.report, got.report);
                check_field("position", want.position, got.position);
                check_field("button", want.button, got.button);
                check_field("edge", want.edge_state, got.edge_state);
            end
        end
    end

    // Watchdog: no handshake on either side for too long ends the run.
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles == QUIET_LIMIT)
        begin
            $display("testbench failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial
    begin
        int phase;
        int n;
        rst_n        = 1'b0;
        s_tvalid     = 1'b0;
        s_tdata      = '0;
        s_tuser      = '0;
        m_tready     = 1'b0;
        cfg_we       = 1'b0;
        cfg_index    = CFG_UP_THRESHOLD;
        cfg_data     = '0;
        mismatches   = 0;
        quiet_cycles = 0;
        sender_calm  = 1'b0;
        taker_calm   = 1'b0;
        held         = PRESS_IDLE;
        run_left     = 0;
        reset_model();
        build_plan();
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        foreach (plan[i])
        begin
            if (plan[i].is_write)
                write_register(plan[i].reg_idx, plan[i].reg_value);
            else
                send_request(plan[i].mode, plan[i].sample, plan[i].cmd,
                             plan[i].typed, plan[i].want);
        end

        for (phase = 0; phase < PHASES; phase++)
        begin
            case (phase)
                0:       apply_settings(700, 300, 3, 100, 0, 500);
                1:       apply_settings(1023, 0, 0, 0, 127, 1023);
                2:       apply_settings(0, 1023, 65535, 127, 100, 0);
                3:       apply_settings(0, 0, 1, 63, 64, 1000);
                default: apply_settings($urandom_range(1023, 0), $urandom_range(1023, 0),
                                        $urandom_range(12, 0), $urandom_range(127, 0),
                                        $urandom_range(127, 0), $urandom_range(1023, 0));
            endcase
            for (n = 0; n < PHASE_ITEMS; n++)
                random_request();
        end

        s_tvalid <= 1'b0;
        while (pending_results.size() != 0)
            @(negedge clk);
        repeat (8) @(negedge clk);   // catch any stray result
        if (mismatches == 0)
            $display("testbench passed");
        else
            $display("testbench failed");
        $finish;
    end

endmodule

>>> sim.f
+incdir+rtl
rtl/cmbc_pkg.sv
rtl/cmbc_queue.sv
rtl/cmbc_front.sv
rtl/cmbc_back.sv
rtl/cover_motor_button_controller.sv
rtl/cmbc_checker.sv
test/testbench.sv
